FILE: hw/rtl/mbs_pkg.sv
// ----------------------------------------------------------------------------
// mbs_pkg: shared types and constants of the maze backtracker step block
// Field widths, op and register codes, and the result record passed from
// the step core to the output stage.
// ----------------------------------------------------------------------------
package mbs_pkg;

  localparam int RND_W     = 16;  // random word
  localparam int CFG_W     = 7;   // dimension registers
  localparam int CFG_IDX_W = 1;   // register index
  localparam int XY_W      = 6;   // cell_x / cell_y result fields
  localparam int MOVE_W    = 3;   // move result field
  localparam int MIN_DIM   = 3;

  localparam logic [CFG_W-1:0] DIM_RESET = 7'd21;

  // op codes
  localparam logic OP_START = 1'b0;
  localparam logic OP_STEP  = 1'b1;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 1'b1;

  // move codes
  localparam logic [MOVE_W-1:0] MV_NONE  = 3'd0;
  localparam logic [MOVE_W-1:0] MV_UP    = 3'd1;
  localparam logic [MOVE_W-1:0] MV_LEFT  = 3'd2;
  localparam logic [MOVE_W-1:0] MV_DOWN  = 3'd3;
  localparam logic [MOVE_W-1:0] MV_RIGHT = 3'd4;

  typedef struct packed {
    logic [XY_W-1:0]   cell_x;
    logic [XY_W-1:0]   cell_y;
    logic [MOVE_W-1:0] move;
    logic              finished;
  } res_t;

endpackage

FILE: hw/rtl/mbs_grid_mem.sv
// ----------------------------------------------------------------------------
// mbs_grid_mem: maze grid storage
// One word per grid row, one bit per column (1 = open). Bit-masked write,
// synchronous (registered) read.
// ----------------------------------------------------------------------------
module mbs_grid_mem #(
  parameter int ROWS = 64,
  parameter int COLS = 64
) (
  input  logic                    clk_i,
  input  logic                    we_i,
  input  logic [$clog2(ROWS)-1:0] waddr_i,
  input  logic [COLS-1:0]         wmask_i,
  input  logic [COLS-1:0]         wdata_i,
  input  logic [$clog2(ROWS)-1:0] raddr_i,
  output logic [COLS-1:0]         rdata_o
);

  logic [COLS-1:0] mem [ROWS];

  always_ff @(posedge clk_i) begin
    for (int b = 0; b < COLS; b++) begin
      if (we_i && wmask_i[b]) begin
        mem[waddr_i][b] <= wdata_i[b];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

FILE: hw/rtl/mbs_stack_mem.sv
// ----------------------------------------------------------------------------
// mbs_stack_mem: backtrack stack storage
// Simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module mbs_stack_mem #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 12,
  parameter int AW    = 10
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

FILE: hw/rtl/mbs_core.sv
// ----------------------------------------------------------------------------
// mbs_core: step sequencer
// Reads stack top and three grid rows, picks a direction, writes the carved
// cells back row by row and pushes or pops the stack.
// ----------------------------------------------------------------------------
module mbs_core #(
  parameter int MAX_DIM     = 64,
  parameter int STACK_DEPTH = 1024,
  parameter int DW          = $clog2(MAX_DIM + 1)
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic                     in_op_i,
  input  logic [mbs_pkg::RND_W-1:0] in_rnd_i,
  input  logic [DW-1:0]            width_i,
  input  logic [DW-1:0]            height_i,
  output logic                     res_valid_o,
  input  logic                     res_ready_i,
  output mbs_pkg::res_t            res_o
);

  localparam int CW = $clog2(MAX_DIM);
  localparam int EW = DW + 1;
  localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int NW = $clog2(STACK_DEPTH + 1);
  localparam int SW = 2 * CW;
  localparam logic [15:0] RECIP3 = 16'hAAAB;  // ceil(2^17 / 3)

  typedef enum logic [3:0] {
    S_IDLE, S_CLEAR, S_ROW0, S_ROW1, S_ROW2, S_PICK, S_WR1, S_WR2, S_EMIT
  } state_e;

  state_e                     state_q;
  logic [CW-1:0]              x_q, y_q, clr_q;
  logic [mbs_pkg::RND_W-1:0]  rnd_q;
  logic [31:0]                prod_q;
  logic [1:0]                 rem3_q;
  logic                       wall_r_q, wall_l_q, wall_d_q;
  logic [mbs_pkg::MOVE_W-1:0] move_q;
  logic [NW-1:0]              cnt_q;
  mbs_pkg::res_t              res_q;

  // memory ports
  logic            g_we;
  logic [CW-1:0]   g_waddr, g_raddr;
  logic [MAX_DIM-1:0] g_wmask, g_wdata, g_rdata;
  logic            s_we;
  logic [AW-1:0]   s_waddr, s_raddr;
  logic [SW-1:0]   s_wdata, s_rdata;

  logic accept;
  logic [EW-1:0] x_e, y_e, w_e, h_e;
  logic in_r, in_d, in_l, in_u;
  logic [CW-1:0] x_p1, x_p2, x_m1, x_m2, y_p1, y_p2, y_m1, y_m2;
  logic [CW-1:0] idx_r, idx_l;
  logic wall_u;
  logic [3:0] flags;
  logic [2:0] n_cand;
  logic [1:0] sel;
  logic [mbs_pkg::MOVE_W-1:0] move_d;
  logic [NW-1:0] cnt_pick;
  logic push_ok;
  logic [CW-1:0] tx, ty;
  logic [MAX_DIM-1:0] bit_x, clr_row;
  logic [15:0] q3;

  function automatic logic [MAX_DIM-1:0] onehot(input logic [CW-1:0] k);
    onehot = {{(MAX_DIM-1){1'b0}}, 1'b1} << k;
  endfunction

  assign accept     = in_valid_i && in_ready_o;
  assign in_ready_o = (state_q == S_IDLE);

  // bounds against the dimensions in use
  assign x_e  = EW'(x_q);
  assign y_e  = EW'(y_q);
  assign w_e  = EW'(width_i);
  assign h_e  = EW'(height_i);
  assign in_r = (x_e + EW'(2)) < w_e;
  assign in_d = (y_e + EW'(2)) < h_e;
  assign in_l = x_e >= EW'(2);
  assign in_u = y_e >= EW'(2);

  assign x_p1 = x_q + CW'(1);
  assign x_p2 = x_q + CW'(2);
  assign x_m1 = x_q - CW'(1);
  assign x_m2 = x_q - CW'(2);
  assign y_p1 = y_q + CW'(1);
  assign y_p2 = y_q + CW'(2);
  assign y_m1 = y_q - CW'(1);
  assign y_m2 = y_q - CW'(2);

  // keep bit indexes inside the row when a neighbour is out of bounds
  assign idx_r = in_r ? x_p2 : x_q;
  assign idx_l = in_l ? x_m2 : x_q;
  assign wall_u = in_u && !g_rdata[x_q];

  // candidate order: right, down, left, up
  assign flags  = {wall_u, wall_l_q, wall_d_q, wall_r_q};
  assign n_cand = 3'($countones(flags));

  always_comb begin
    unique case (n_cand)
      3'd2:    sel = {1'b0, rnd_q[0]};
      3'd3:    sel = rem3_q;
      3'd4:    sel = rnd_q[1:0];
      default: sel = 2'd0;
    endcase
  end

  always_comb begin
    logic [1:0] seen;
    logic       found;
    seen   = 2'd0;
    found  = 1'b0;
    move_d = mbs_pkg::MV_NONE;
    for (int i = 0; i < 4; i++) begin
      if (flags[i] && !found) begin
        if (seen == sel) begin
          found = 1'b1;
          unique case (i)
            0:       move_d = mbs_pkg::MV_RIGHT;
            1:       move_d = mbs_pkg::MV_DOWN;
            2:       move_d = mbs_pkg::MV_LEFT;
            default: move_d = mbs_pkg::MV_UP;
          endcase
        end
        seen = seen + 2'd1;
      end
    end
  end

  // carved target cell
  always_comb begin
    tx = x_q;
    ty = y_q;
    unique case (move_d)
      mbs_pkg::MV_RIGHT: tx = x_p2;
      mbs_pkg::MV_LEFT:  tx = x_m2;
      mbs_pkg::MV_DOWN:  ty = y_p2;
      mbs_pkg::MV_UP:    ty = y_m2;
      default: ;
    endcase
  end

  assign push_ok  = cnt_q < NW'(STACK_DEPTH);
  assign cnt_pick = (move_d == mbs_pkg::MV_NONE) ? (cnt_q - NW'(1)) :
                    (push_ok ? (cnt_q + NW'(1)) : cnt_q);

  // q3 = 3 * floor(rnd / 3)
  assign q3 = 16'({prod_q[31:17], 1'b0}) + 16'(prod_q[31:17]);

  assign bit_x   = onehot(x_q);
  assign clr_row = ((clr_q == CW'(0)) ? onehot(CW'(1)) : '0) |
                   ((EW'(clr_q) == (h_e - EW'(1))) ? onehot(CW'(w_e - EW'(2))) : '0);

  // grid port
  always_comb begin
    g_we    = 1'b0;
    g_waddr = y_q;
    g_wmask = bit_x;
    g_wdata = '1;
    unique case (state_q)
      S_CLEAR: begin
        g_we    = 1'b1;
        g_waddr = clr_q;
        g_wmask = '1;
        g_wdata = clr_row;
      end
      S_PICK: begin
        g_we = 1'b1;
        if (move_d == mbs_pkg::MV_RIGHT) begin
          g_wmask = bit_x | onehot(x_p1) | onehot(x_p2);
        end else if (move_d == mbs_pkg::MV_LEFT) begin
          g_wmask = bit_x | onehot(x_m1) | onehot(x_m2);
        end
      end
      S_WR1: begin
        g_we    = 1'b1;
        g_waddr = (move_q == mbs_pkg::MV_UP) ? y_m1 : y_p1;
      end
      S_WR2: begin
        g_we    = 1'b1;
        g_waddr = (move_q == mbs_pkg::MV_UP) ? y_m2 : y_p2;
      end
      default: ;
    endcase
  end

  always_comb begin
    unique case (state_q)
      S_ROW0:  g_raddr = s_rdata[SW-1:CW];
      S_ROW1:  g_raddr = in_d ? y_p2 : y_q;
      S_ROW2:  g_raddr = in_u ? y_m2 : y_q;
      default: g_raddr = y_q;
    endcase
  end

  // stack port
  assign s_raddr = (cnt_q == '0) ? '0 : AW'(cnt_q - NW'(1));
  always_comb begin
    s_we    = 1'b0;
    s_waddr = AW'(cnt_q);
    s_wdata = {ty, tx};
    if (accept && in_op_i == mbs_pkg::OP_START) begin
      s_we    = 1'b1;
      s_waddr = '0;
      s_wdata = {CW'(1), CW'(1)};
    end else if (state_q == S_PICK && move_d != mbs_pkg::MV_NONE && push_ok) begin
      s_we = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      clr_q   <= '0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            rnd_q <= in_rnd_i;
            if (in_op_i == mbs_pkg::OP_START) begin
              cnt_q   <= NW'(1);
              clr_q   <= '0;
              res_q   <= '{cell_x: 6'd1, cell_y: 6'd1,
                           move: mbs_pkg::MV_NONE, finished: 1'b0};
              state_q <= S_CLEAR;
            end else if (cnt_q == '0) begin
              res_q   <= '{cell_x: 6'd0, cell_y: 6'd0,
                           move: mbs_pkg::MV_NONE, finished: 1'b1};
              state_q <= S_EMIT;
            end else begin
              state_q <= S_ROW0;
            end
          end
        end
        S_CLEAR: begin
          clr_q <= clr_q + CW'(1);
          if (clr_q == CW'(MAX_DIM - 1)) begin
            state_q <= S_EMIT;
          end
        end
        S_ROW0: begin
          x_q     <= s_rdata[CW-1:0];
          y_q     <= s_rdata[SW-1:CW];
          prod_q  <= 32'(rnd_q) * 32'(RECIP3);
          state_q <= S_ROW1;
        end
        S_ROW1: begin
          wall_r_q <= in_r && !g_rdata[idx_r];
          wall_l_q <= in_l && !g_rdata[idx_l];
          rem3_q   <= 2'(rnd_q - q3);
          state_q  <= S_ROW2;
        end
        S_ROW2: begin
          wall_d_q <= in_d && !g_rdata[x_q];
          state_q  <= S_PICK;
        end
        S_PICK: begin
          move_q <= move_d;
          cnt_q  <= cnt_pick;
          res_q  <= '{cell_x: 6'(x_q), cell_y: 6'(y_q), move: move_d,
                      finished: (cnt_pick == '0)};
          if (move_d == mbs_pkg::MV_UP || move_d == mbs_pkg::MV_DOWN) begin
            state_q <= S_WR1;
          end else begin
            state_q <= S_EMIT;
          end
        end
        S_WR1:   state_q <= S_WR2;
        S_WR2:   state_q <= S_EMIT;
        S_EMIT: begin
          if (res_ready_i) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign res_valid_o = (state_q == S_EMIT);
  assign res_o       = res_q;

  mbs_grid_mem #(
    .ROWS (MAX_DIM),
    .COLS (MAX_DIM)
  ) u_grid (
    .clk_i   (clk_i),
    .we_i    (g_we),
    .waddr_i (g_waddr),
    .wmask_i (g_wmask),
    .wdata_i (g_wdata),
    .raddr_i (g_raddr),
    .rdata_o (g_rdata)
  );

  mbs_stack_mem #(
    .DEPTH (STACK_DEPTH),
    .WIDTH (SW),
    .AW    (AW)
  ) u_stack (
    .clk_i   (clk_i),
    .we_i    (s_we),
    .waddr_i (s_waddr),
    .wdata_i (s_wdata),
    .raddr_i (s_raddr),
    .rdata_o (s_rdata)
  );

  // stack never grows past its depth
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= NW'(STACK_DEPTH))
    else $error("stack count exceeds depth");

  // a finished result only with an empty stack
  a_fin_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EMIT && res_q.finished) |-> (cnt_q == '0))
    else $error("finished flagged with entries left");

  // a carve leaves the stack non-empty
  a_carve_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EMIT && res_q.move != mbs_pkg::MV_NONE) |-> (cnt_q != '0))
    else $error("carve reported with empty stack");

  // extra row writes only for vertical carves
  a_vert_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WR1) |-> (move_q == mbs_pkg::MV_UP || move_q == mbs_pkg::MV_DOWN))
    else $error("vertical write pass on horizontal move");

  // stack top read only when the stack held entries
  a_read_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_ROW0) |-> ($past(cnt_q) != '0))
    else $error("stack read on empty stack");

endmodule

FILE: hw/rtl/maze_backtracker_step_top.sv
// ----------------------------------------------------------------------------
// maze_backtracker_step_top: recursive-backtracker maze generator, one step
// per item
// Config registers, dimension clamping, step core and output register.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis: one item per walk command. tuser = op (0 start, 1 step),
//   tdata = random word. m_axis: one result item per input item,
//   tdata = cell_x, cell_y, move; tlast = finished (stack empty).
//   cfg: write channel, index 0 = maze_width, 1 = maze_height; always ready,
//   write only while idle. Dimensions in use are clamped to 3..MAX_DIM.
// Sequence per item:
//   step, pop or carve: stack top read, three grid row reads through the
//     single read port of the row memory, then one row write per carved row
//     (a vertical carve also writes the two rows below or above);
//   step on empty stack: finished result without row reads; start: grid
//     cleared one row per cycle.
//   The result reaches m_axis through the output register.
// Reset: empty stack, dimensions 21 x 21, no grid clearing pass (a step is
//   only able to read the grid after a start item cleared it).
// Stall: the output register holds a result until taken; the next item is
//   accepted meanwhile and its step runs, waiting only to hand over.
// ----------------------------------------------------------------------------
module maze_backtracker_step_top #(
  parameter int MAX_DIM     = 64,
  parameter int STACK_DEPTH = 1024
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // input items
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [15:0]                   s_axis_tdata,   // [15:0] random_word
  input  logic [0:0]                    s_axis_tuser,   // [0] op
  // result items
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [15:0]                   m_axis_tdata,   // [5:0] cell_x, [11:6] cell_y,
                                                        // [14:12] move, [15] zero
  output logic                          m_axis_tlast,   // finished
  // configuration writes
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [mbs_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [mbs_pkg::CFG_W-1:0]     cfg_data_i
);

  localparam int DW = $clog2(MAX_DIM + 1);
  localparam int SatW = (DW > mbs_pkg::CFG_W) ? DW : mbs_pkg::CFG_W;

  logic [mbs_pkg::CFG_W-1:0] width_q, height_q;
  logic [DW-1:0]             width_use, height_use;
  logic                      out_valid_q;
  mbs_pkg::res_t             out_q;
  logic                      res_valid, res_ready;
  mbs_pkg::res_t             res;

  // clamp a register to 3..MAX_DIM
  function automatic logic [DW-1:0] clamp_dim(input logic [mbs_pkg::CFG_W-1:0] r);
    logic [SatW-1:0] v;
    v = SatW'(r);
    if (v < SatW'(mbs_pkg::MIN_DIM)) begin
      clamp_dim = DW'(mbs_pkg::MIN_DIM);
    end else if (v > SatW'(MAX_DIM)) begin
      clamp_dim = DW'(MAX_DIM);
    end else begin
      clamp_dim = DW'(v);
    end
  endfunction

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= mbs_pkg::DIM_RESET;
      height_q <= mbs_pkg::DIM_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        mbs_pkg::REG_WIDTH:  width_q  <= cfg_data_i;
        mbs_pkg::REG_HEIGHT: height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign width_use  = clamp_dim(width_q);
  assign height_use = clamp_dim(height_q);

  mbs_core #(
    .MAX_DIM     (MAX_DIM),
    .STACK_DEPTH (STACK_DEPTH),
    .DW          (DW)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_op_i     (s_axis_tuser[0]),
    .in_rnd_i    (s_axis_tdata),
    .width_i     (width_use),
    .height_i    (height_use),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res)
  );

  // output register: free when empty or being drained this cycle
  assign res_ready = !out_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {1'b0, out_q.move, out_q.cell_y, out_q.cell_x};
  assign m_axis_tlast  = out_q.finished;

endmodule
